// ----- sv/mrp_pkg.sv -----
`default_nettype none

package mrp_pkg;

  // frame limits
  localparam int unsigned PAYLOAD_MAX = 128;
  localparam int unsigned FRAME_MAX   = 256;

  // widths of the frame bookkeeping
  localparam int unsigned LEN_W = 9;

  // crc-16, reflected form
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // supported function codes
  localparam logic [7:0] FUNC_READ_HOLDING  = 8'h03;
  localparam logic [7:0] FUNC_WRITE_MULTIPLE = 8'h10;

  // slave id after reset
  localparam logic [7:0] SLAVE_ADDRESS_RESET = 8'h02;

  typedef enum logic [2:0] {
    PH_WAIT_ID = 3'd0,
    PH_FUNC    = 3'd1,
    PH_ADDR    = 3'd2,
    PH_QTY     = 3'd3,
    PH_COUNT   = 3'd4,
    PH_DATA    = 3'd5,
    PH_CRC     = 3'd6
  } phase_e;

endpackage

`default_nettype wire

// ----- sv/mrp_if.sv -----
`default_nettype none

// received byte channel
interface mrp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// per-byte parse result channel
interface mrp_out_if;
  logic        valid;
  logic        ready;
  logic        payload_valid;
  logic [6:0]  payload_index;
  logic [7:0]  payload_data;
  logic        frame_done;
  logic        crc_match;
  logic [7:0]  function_code;
  logic [15:0] register_start;
  logic [15:0] register_quantity;
  logic [7:0]  data_byte_count;
  logic [15:0] good_frames;
  logic [15:0] bad_frames;

  modport source (
    output valid, output payload_valid, output payload_index, output payload_data,
    output frame_done, output crc_match, output function_code, output register_start,
    output register_quantity, output data_byte_count, output good_frames,
    output bad_frames, input ready
  );
  modport sink (
    input valid, input payload_valid, input payload_index, input payload_data,
    input frame_done, input crc_match, input function_code, input register_start,
    input register_quantity, input data_byte_count, input good_frames,
    input bad_frames, output ready
  );
endinterface

`default_nettype wire

// ----- sv/modbus_rtu_request_parser.sv -----
// result word: registered; a byte accepted at one clock edge shows its result word after that edge
// throughput: one byte per cycle; the byte-wide crc step and the phase logic sit between
//   the parser state registers and the result register; input ready is high while the
//   result register is empty or being read, so a result stall holds the input
// reset (rst_ni low, asynchronous): parser waits for a slave id, crc 0xFFFF,
//   frame fields and frame counters zero, slave id 2, result register empty
`default_nettype none

module modbus_rtu_request_parser
  import mrp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       slave_address_we_i,
  input  wire logic [7:0] slave_address_i,
  mrp_in_if.sink          rx_i,
  mrp_out_if.source       res_o
);

  // configuration
  logic [7:0] slave_address_q;

  // parser state
  phase_e           phase_q, phase_d;
  logic             second_q, second_d;
  logic [15:0]      crc_q, crc_d;
  logic [7:0]       func_q, func_d;
  logic [15:0]      start_q, start_d;
  logic [15:0]      qty_q, qty_d;
  logic [7:0]       cnt_q, cnt_d;
  logic [7:0]       pay_cnt_q, pay_cnt_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [15:0]      rcrc_q, rcrc_d;
  logic [15:0]      good_q, good_d;
  logic [15:0]      bad_q, bad_d;

  // values after this byte, before any end-of-frame clear
  phase_e           phase_upd;
  logic             second_upd;
  logic [7:0]       func_upd;
  logic [15:0]      start_upd;
  logic [15:0]      qty_upd;
  logic [7:0]       cnt_upd;
  logic [7:0]       pay_cnt_upd;
  logic [15:0]      rcrc_upd;
  logic [15:0]      crc_upd;
  logic [LEN_W-1:0] len_upd;
  logic             take;
  logic             pv;
  logic             done;
  logic             match;
  logic             drop;
  logic             clear;

  // result register
  logic        out_valid_q, out_valid_d;
  logic        pv_q;
  logic [6:0]  pidx_q;
  logic [7:0]  pdata_q;
  logic        done_q;
  logic        match_q;
  logic [7:0]  o_func_q;
  logic [15:0] o_start_q;
  logic [15:0] o_qty_q;
  logic [7:0]  o_cnt_q;

  logic        accept;
  logic [7:0]  b;
  logic [15:0] crc_step;
  logic [16:0] read_bytes;

  assign b        = rx_i.rx_byte;
  // a new byte goes in whenever the result register is free or being emptied
  assign rx_i.ready = !out_valid_q || res_o.ready;
  assign accept   = rx_i.valid && rx_i.ready;

  mrp_crc_step u_crc (
    .crc_i  (crc_q),
    .data_i (b),
    .crc_o  (crc_step)
  );

  // 0x03 byte count is twice the quantity, taken as the low quantity byte arrives
  assign read_bytes = {qty_q[15:8], b, 1'b0};

  // per-phase decode of the incoming byte
  always_comb begin
    phase_upd   = phase_q;
    second_upd  = second_q;
    func_upd    = func_q;
    start_upd   = start_q;
    qty_upd     = qty_q;
    cnt_upd     = cnt_q;
    pay_cnt_upd = pay_cnt_q;
    rcrc_upd    = rcrc_q;
    take        = 1'b0;
    pv          = 1'b0;
    done        = 1'b0;
    drop        = 1'b0;

    unique case (phase_q)
      PH_WAIT_ID: begin
        if (b == slave_address_q) begin
          take      = 1'b1;
          phase_upd = PH_FUNC;
        end
      end
      PH_FUNC: begin
        if (b == FUNC_WRITE_MULTIPLE || b == FUNC_READ_HOLDING) begin
          take      = 1'b1;
          func_upd  = b;
          phase_upd = PH_ADDR;
        end else begin
          drop = 1'b1;
        end
      end
      PH_ADDR: begin
        take = 1'b1;
        if (!second_q) begin
          start_upd  = {b, 8'h00};
          second_upd = 1'b1;
        end else begin
          start_upd  = {start_q[15:8], b};
          second_upd = 1'b0;
          phase_upd  = PH_QTY;
        end
      end
      PH_QTY: begin
        take = 1'b1;
        if (!second_q) begin
          qty_upd    = {b, 8'h00};
          second_upd = 1'b1;
        end else begin
          qty_upd    = {qty_q[15:8], b};
          second_upd = 1'b0;
          // register read: no payload follows
          if (func_q == FUNC_READ_HOLDING) begin
            phase_upd = PH_CRC;
          end else begin
            phase_upd = PH_COUNT;
          end
        end
      end
      PH_COUNT: begin
        take = 1'b1;
        if (b > 8'(PAYLOAD_MAX)) begin
          cnt_upd = 8'(PAYLOAD_MAX);
        end else begin
          cnt_upd = b;
        end
        // an empty write goes straight to the crc bytes
        phase_upd = (cnt_upd == 8'd0) ? PH_CRC : PH_DATA;
      end
      PH_DATA: begin
        if (pay_cnt_q < cnt_q) begin
          take        = 1'b1;
          pv          = 1'b1;
          pay_cnt_upd = pay_cnt_q + 8'd1;
        end
        if (pay_cnt_upd >= cnt_q) begin
          phase_upd = PH_CRC;
        end
      end
      PH_CRC: begin
        // crc arrives low byte first
        if (!second_q) begin
          rcrc_upd   = {8'h00, b};
          second_upd = 1'b1;
        end else begin
          rcrc_upd   = {b, rcrc_q[7:0]};
          second_upd = 1'b0;
          done       = 1'b1;
        end
      end
      default: begin
        drop = 1'b1;
      end
    endcase

    // read byte count saturates at the payload limit
    if (phase_q == PH_QTY && second_q && func_q == FUNC_READ_HOLDING) begin
      if (read_bytes > 17'(PAYLOAD_MAX)) begin
        cnt_upd = 8'(PAYLOAD_MAX);
      end else begin
        cnt_upd = read_bytes[7:0];
      end
    end
  end

  // crc and length only move on bytes that the crc covers
  assign crc_upd = take ? crc_step : crc_q;
  assign len_upd = take ? len_q + LEN_W'(1) : len_q;
  assign match   = done && (rcrc_upd == crc_upd);
  // oversize frames are dropped silently; wrong function or end of frame also clears
  assign clear   = drop || done || (len_upd > LEN_W'(FRAME_MAX));

  // next state of the parser
  always_comb begin
    phase_d   = phase_q;
    second_d  = second_q;
    crc_d     = crc_q;
    func_d    = func_q;
    start_d   = start_q;
    qty_d     = qty_q;
    cnt_d     = cnt_q;
    pay_cnt_d = pay_cnt_q;
    len_d     = len_q;
    rcrc_d    = rcrc_q;
    good_d    = good_q;
    bad_d     = bad_q;
    if (accept) begin
      if (clear) begin
        phase_d   = PH_WAIT_ID;
        second_d  = 1'b0;
        crc_d     = CRC_INIT;
        func_d    = '0;
        start_d   = '0;
        qty_d     = '0;
        cnt_d     = '0;
        pay_cnt_d = '0;
        len_d     = '0;
        rcrc_d    = '0;
      end else begin
        phase_d   = phase_upd;
        second_d  = second_upd;
        crc_d     = crc_upd;
        func_d    = func_upd;
        start_d   = start_upd;
        qty_d     = qty_upd;
        cnt_d     = cnt_upd;
        pay_cnt_d = pay_cnt_upd;
        len_d     = len_upd;
        rcrc_d    = rcrc_upd;
      end
      if (done && match) begin
        good_d = good_q + 16'd1;
      end
      if (done && !match) begin
        bad_d = bad_q + 16'd1;
      end
    end
  end

  // result register handshake
  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_address_q <= SLAVE_ADDRESS_RESET;
      phase_q         <= PH_WAIT_ID;
      second_q        <= 1'b0;
      crc_q           <= CRC_INIT;
      func_q          <= '0;
      start_q         <= '0;
      qty_q           <= '0;
      cnt_q           <= '0;
      pay_cnt_q       <= '0;
      len_q           <= '0;
      rcrc_q          <= '0;
      good_q          <= '0;
      bad_q           <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      if (slave_address_we_i) begin
        slave_address_q <= slave_address_i;
      end
      phase_q     <= phase_d;
      second_q    <= second_d;
      crc_q       <= crc_d;
      func_q      <= func_d;
      start_q     <= start_d;
      qty_q       <= qty_d;
      cnt_q       <= cnt_d;
      pay_cnt_q   <= pay_cnt_d;
      len_q       <= len_d;
      rcrc_q      <= rcrc_d;
      good_q      <= good_d;
      bad_q       <= bad_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result word payload, loaded on every accepted byte
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pv_q      <= pv;
      pidx_q    <= pv ? pay_cnt_q[6:0] : 7'd0;
      pdata_q   <= pv ? b : 8'd0;
      done_q    <= done;
      match_q   <= match;
      // frame fields as parsed so far, shown before the end-of-frame clear
      o_func_q  <= func_upd;
      o_start_q <= start_upd;
      o_qty_q   <= qty_upd;
      o_cnt_q   <= cnt_upd;
    end
  end

  assign res_o.valid             = out_valid_q;
  assign res_o.payload_valid     = pv_q;
  assign res_o.payload_index     = pidx_q;
  assign res_o.payload_data      = pdata_q;
  assign res_o.frame_done        = done_q;
  assign res_o.crc_match         = match_q;
  assign res_o.function_code     = o_func_q;
  assign res_o.register_start    = o_start_q;
  assign res_o.register_quantity = o_qty_q;
  assign res_o.data_byte_count   = o_cnt_q;
  // counters registered already; they only move on accepted bytes
  assign res_o.good_frames       = good_q;
  assign res_o.bad_frames        = bad_q;

endmodule

`default_nettype wire

// ----- sv/mrp_crc_step.sv -----
`default_nettype none

// one byte through the reflected crc-16, eight bit steps unrolled
module mrp_crc_step
  import mrp_pkg::*;
(
  input  wire logic [15:0] crc_i,
  input  wire logic [7:0]  data_i,
  output logic      [15:0] crc_o
);

  always_comb begin
    logic [15:0] c;
    c = crc_i ^ {8'h00, data_i};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_o = c;
  end

endmodule

`default_nettype wire

// ----- bench/modbus_rtu_request_parser_tb.sv -----
`timescale 1ns / 100ps

module modbus_rtu_request_parser_tb
  import mrp_pkg::*;
();

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned TARGET_BYTES = 1625;
  localparam int unsigned SETTLE       = 4;
  localparam int unsigned MAX_PRINTS   = 40;

  // one result word as the parser reports it after each byte
  typedef struct packed {
    logic        payload_valid;
    logic [6:0]  payload_index;
    logic [7:0]  payload_data;
    logic        frame_done;
    logic        crc_match;
    logic [7:0]  function_code;
    logic [15:0] register_start;
    logic [15:0] register_quantity;
    logic [7:0]  data_byte_count;
    logic [15:0] good_frames;
    logic [15:0] bad_frames;
  } parse_word_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       slave_address_we_i;
  logic [7:0] slave_address_i;

  mrp_in_if  rx_if ();
  mrp_out_if res_if ();

  modbus_rtu_request_parser dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .slave_address_we_i (slave_address_we_i),
    .slave_address_i    (slave_address_i),
    .rx_i               (rx_if),
    .res_o              (res_if)
  );

  always #5 clk_i = ~clk_i;

  // parser state mirrored on the bench side
  logic [7:0]  device_id;
  phase_e      phase;
  logic        second_half;
  logic [15:0] crc_run;
  logic [7:0]  frame_func;
  logic [15:0] frame_start;
  logic [15:0] frame_qty;
  logic [7:0]  frame_count;
  logic [7:0]  payload_seen;
  logic [8:0]  covered_len;
  logic [15:0] crc_rx;
  logic [15:0] good_total;
  logic [15:0] bad_total;

  parse_word_t expected_words[$];
  int unsigned error_count    = 0;
  int unsigned bytes_accepted = 0;
  int unsigned words_checked  = 0;
  int unsigned cycle_count    = 0;
  bit          sender_quiet   = 1'b0;

  // crc-16 over one byte, lsb first
  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction

  // back to waiting for an id; counters and slave id survive
  function automatic void clear_frame();
    phase        = PH_WAIT_ID;
    second_half  = 1'b0;
    crc_run      = CRC_INIT;
    frame_func   = '0;
    frame_start  = '0;
    frame_qty    = '0;
    frame_count  = '0;
    payload_seen = '0;
    covered_len  = '0;
    crc_rx       = '0;
  endfunction

  // byte that counts toward the frame crc and length
  function automatic void absorb(input logic [7:0] b);
    crc_run     = crc16_step(crc_run, b);
    covered_len = covered_len + 9'd1;
  endfunction

  // advance the mirrored parser by one byte and build the word it must report
  function automatic parse_word_t parse_byte(input logic [7:0] b);
    parse_word_t w;
    bit          drop;
    logic [16:0] doubled;
    w    = '0;
    drop = 1'b0;
    case (phase)
      PH_WAIT_ID: begin
        if (b == device_id) begin
          absorb(b);
          phase = PH_FUNC;
        end
      end
      PH_FUNC: begin
        // a bad function byte drops the frame and is not retried as an id
        if (b == FUNC_WRITE_MULTIPLE || b == FUNC_READ_HOLDING) begin
          absorb(b);
          frame_func = b;
          phase      = PH_ADDR;
        end else begin
          drop = 1'b1;
        end
      end
      PH_ADDR: begin
        absorb(b);
        if (!second_half) begin
          frame_start = {b, 8'h00};
          second_half = 1'b1;
        end else begin
          frame_start[7:0] = b;
          second_half      = 1'b0;
          phase            = PH_QTY;
        end
      end
      PH_QTY: begin
        absorb(b);
        if (!second_half) begin
          frame_qty   = {b, 8'h00};
          second_half = 1'b1;
        end else begin
          frame_qty[7:0] = b;
          second_half    = 1'b0;
          if (frame_func == FUNC_READ_HOLDING) begin
            // read: byte count is twice the quantity, saturated, crc next
            doubled     = {frame_qty, 1'b0};
            frame_count = (doubled > PAYLOAD_MAX) ? 8'(PAYLOAD_MAX) : doubled[7:0];
            phase       = PH_CRC;
          end else begin
            phase = PH_COUNT;
          end
        end
      end
      PH_COUNT: begin
        absorb(b);
        frame_count = (b > PAYLOAD_MAX) ? 8'(PAYLOAD_MAX) : b;
        // zero count skips straight to the crc bytes
        phase = (frame_count == 8'd0) ? PH_CRC : PH_DATA;
      end
      PH_DATA: begin
        if (payload_seen < frame_count) begin
          absorb(b);
          w.payload_valid = 1'b1;
          w.payload_index = payload_seen[6:0];
          w.payload_data  = b;
          payload_seen    = payload_seen + 8'd1;
        end
        if (payload_seen >= frame_count) phase = PH_CRC;
      end
      PH_CRC: begin
        // crc arrives low byte first
        if (!second_half) begin
          crc_rx      = {8'h00, b};
          second_half = 1'b1;
        end else begin
          crc_rx[15:8] = b;
          second_half  = 1'b0;
          w.frame_done = 1'b1;
          w.crc_match  = (crc_rx == crc_run);
          if (w.crc_match) good_total = good_total + 16'd1;
          else bad_total = bad_total + 16'd1;
        end
      end
      default: drop = 1'b1;
    endcase
    if (covered_len > FRAME_MAX) drop = 1'b1;
    w.function_code     = frame_func;
    w.register_start    = frame_start;
    w.register_quantity = frame_qty;
    w.data_byte_count   = frame_count;
    w.good_frames       = good_total;
    w.bad_frames        = bad_total;
    if (drop || w.frame_done) clear_frame();
    return w;
  endfunction

  // mostly short waits, now and then a long one
  function automatic int unsigned pick_wait();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string msg);
    if (error_count < MAX_PRINTS) $display("mismatch at word %0d: %s", words_checked, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  // send one byte; returns at the edge that accepted it
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = sender_quiet ? 0 : pick_wait();
    @(negedge clk_i);
    if (gap > 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk_i); while (rx_if.ready !== 1'b1);
    expected_words.push_back(parse_byte(b));
    bytes_accepted++;
  endtask

  // stop sending and wait until every expected word has come back
  task automatic wait_results_drained();
    @(negedge clk_i);
    rx_if.valid <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk_i);
  endtask

  task automatic set_slave_address(input logic [7:0] id);
    wait_results_drained();
    repeat (SETTLE) @(negedge clk_i);
    slave_address_we_i <= 1'b1;
    slave_address_i    <= id;
    @(negedge clk_i);
    slave_address_we_i <= 1'b0;
    device_id = id;
  endtask

  // one request frame, crc appended; keep_len > 0 keeps at most keep_len bytes of it
  task automatic send_request(input logic [7:0] id, input logic [7:0] fcode,
                              input logic [15:0] start, input logic [15:0] qty,
                              input logic [7:0] count, input bit bad_crc,
                              input int unsigned keep_len);
    logic [7:0]  frame_q[$];
    logic [15:0] crc;
    int unsigned n;
    frame_q = {id, fcode, start[15:8], start[7:0], qty[15:8], qty[7:0]};
    if (fcode == FUNC_WRITE_MULTIPLE) begin
      frame_q.push_back(count);
      n = (count > PAYLOAD_MAX) ? PAYLOAD_MAX : count;
      repeat (n) frame_q.push_back(8'($urandom()));
    end
    crc = CRC_INIT;
    foreach (frame_q[i]) crc = crc16_step(crc, frame_q[i]);
    if (bad_crc) crc = crc ^ (16'd1 << $urandom_range(0, 15));
    frame_q.push_back(crc[7:0]);
    frame_q.push_back(crc[15:8]);
    if (keep_len != 0) while (frame_q.size() > keep_len) void'(frame_q.pop_back());
    foreach (frame_q[i]) send_byte(frame_q[i]);
  endtask

  // mostly well-formed frames with random content, some noise and broken frames
  task automatic send_random_request();
    logic [7:0]  id;
    logic [7:0]  fcode;
    logic [7:0]  count;
    logic [15:0] qty;
    int unsigned r;
    int unsigned keep_len;
    bit          bad;
    sender_quiet = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 4)) send_byte(8'($urandom()));
    id = ($urandom_range(0, 9) == 0) ? 8'($urandom()) : device_id;
    r  = $urandom_range(0, 99);
    if (r < 45) fcode = FUNC_READ_HOLDING;
    else if (r < 90) fcode = FUNC_WRITE_MULTIPLE;
    else fcode = 8'($urandom());
    qty = $urandom_range(0, 1) ? 16'($urandom_range(0, 70)) : 16'($urandom());
    r   = $urandom_range(0, 99);
    if (r < 80) count = 8'($urandom_range(0, 12));
    else if (r < 92) count = 8'($urandom_range(13, 128));
    else count = 8'($urandom_range(129, 255));
    bad      = ($urandom_range(0, 4) == 0);
    keep_len = ($urandom_range(0, 11) == 0) ? $urandom_range(1, 8) : 0;
    send_request(id, fcode, 16'($urandom()), qty, count, bad, keep_len);
  endtask

  // reset id, field extremes, bad function byte, read count saturation, empty write
  task automatic test_directed_frames();
    sender_quiet = 1'b0;
    send_byte(8'h00);
    send_byte(8'hFF);
    send_request(SLAVE_ADDRESS_RESET, FUNC_READ_HOLDING, 16'h0000, 16'hFFFF, 8'h00, 1'b0, 0);
    send_byte(SLAVE_ADDRESS_RESET);
    send_byte(8'hFF);
    // function byte equal to the id must not restart a frame
    send_byte(SLAVE_ADDRESS_RESET);
    send_byte(SLAVE_ADDRESS_RESET);
    send_request(SLAVE_ADDRESS_RESET, FUNC_WRITE_MULTIPLE, 16'hFFFF, 16'h0000, 8'h00, 1'b1, 0);
  endtask

  // id extremes, a random id, then back to the reset id
  task automatic test_slave_address_settings();
    logic [7:0] ids[4];
    ids = '{8'h00, 8'hFF, 8'($urandom()), SLAVE_ADDRESS_RESET};
    foreach (ids[i]) begin
      set_slave_address(ids[i]);
      repeat (12) send_random_request();
    end
  endtask

  // bulk traffic with periodic full drains and id changes
  task automatic test_random_traffic();
    int unsigned frames;
    frames = 0;
    while (bytes_accepted < TARGET_BYTES) begin
      send_random_request();
      frames++;
      if (frames % 25 == 0) wait_results_drained();
      if (frames % 60 == 0) set_slave_address(8'($urandom()));
    end
  endtask

  // result sink: bursts of ready, random stalls, occasional long ready stretch
  initial begin
    bit          sink_ready;
    int unsigned hold_left;
    res_if.ready = 1'b0;
    sink_ready   = 1'b0;
    hold_left    = 0;
    forever begin
      @(negedge clk_i);
      if (hold_left == 0) begin
        if (sink_ready) begin
          sink_ready = 1'b0;
          hold_left  = pick_wait();
          if (hold_left == 0) begin
            sink_ready = 1'b1;
            hold_left  = $urandom_range(1, 30);
          end
        end else begin
          sink_ready = 1'b1;
          hold_left  = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                   : $urandom_range(1, 8);
        end
      end
      hold_left--;
      res_if.ready <= sink_ready;
    end
  end

  // compare every accepted word with the oldest prediction
  always @(posedge clk_i) begin
    parse_word_t want;
    if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      if (expected_words.size() == 0) begin
        report_mismatch("word with nothing expected");
      end else begin
        want = expected_words.pop_front();
        check_field("payload_valid", res_if.payload_valid, want.payload_valid);
        check_field("payload_index", res_if.payload_index, want.payload_index);
        check_field("payload_data", res_if.payload_data, want.payload_data);
        check_field("frame_done", res_if.frame_done, want.frame_done);
        check_field("crc_match", res_if.crc_match, want.crc_match);
        check_field("function_code", res_if.function_code, want.function_code);
        check_field("register_start", res_if.register_start, want.register_start);
        check_field("register_quantity", res_if.register_quantity, want.register_quantity);
        check_field("data_byte_count", res_if.data_byte_count, want.data_byte_count);
        check_field("good_frames", res_if.good_frames, want.good_frames);
        check_field("bad_frames", res_if.bad_frames, want.bad_frames);
      end
      words_checked++;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    rst_ni             = 1'b0;
    rx_if.valid        = 1'b0;
    rx_if.rx_byte      = 8'h00;
    slave_address_we_i = 1'b0;
    slave_address_i    = 8'h00;
    device_id          = SLAVE_ADDRESS_RESET;
    good_total         = '0;
    bad_total          = '0;
    clear_frame();
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_frames();
    test_slave_address_settings();
    test_random_traffic();

    // let any stray word show up before the verdict
    wait_results_drained();
    repeat (SETTLE) @(negedge clk_i);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
